// ----- rtl/ipv4_universal_hash_top_defines.svh -----
// Assertion helpers shared by the verification files of the hash block.
`ifndef IPV4_UNIVERSAL_HASH_TOP_DEFINES_SVH
`define IPV4_UNIVERSAL_HASH_TOP_DEFINES_SVH

// Concurrent check that is ignored while reset is asserted.
`define IPV4UH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define IPV4UH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ipv4uh_pkg.sv -----
`default_nettype none

package ipv4uh_pkg;

   localparam int ADDR_W      = 32;
   localparam int CHUNK_CFG_W = 5;
   localparam int MOD_W       = 18;
   localparam int COEFF_W     = 18;
   localparam int CSR_DATA_W  = 18;
   localparam int MAX_CHUNKS  = 6;
   localparam int NUM_REGS    = 8;
   localparam int CSR_IDX_W   = $clog2(NUM_REGS);
   localparam int PROD_W      = ADDR_W + COEFF_W;
   // chunks of one address never sum above the address itself
   localparam int SUM_W       = PROD_W;
   // remainder bits resolved per mod cell
   localparam int MOD_STEP    = 2;
   localparam int MOD_CELLS   = (SUM_W + MOD_STEP - 1) / MOD_STEP;
   localparam int DIV_W       = MOD_CELLS * MOD_STEP;

   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [CHUNK_CFG_W-1:0] chunk_cfg_type;
   typedef logic [MOD_W-1:0]       mod_type;
   typedef logic [COEFF_W-1:0]     coeff_type;
   typedef logic [PROD_W-1:0]      prod_type;
   typedef logic [SUM_W-1:0]       sum_type;
   typedef logic [DIV_W-1:0]       div_type;
   typedef logic [CSR_IDX_W-1:0]   csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [MAX_CHUNKS-1:0][COEFF_W-1:0] coeff_vec_type;

   localparam csr_idx_type REG_CHUNK_BITS = CSR_IDX_W'(0);
   localparam csr_idx_type REG_TABLE_SIZE = CSR_IDX_W'(1);
   localparam csr_idx_type REG_COEFF_0    = CSR_IDX_W'(2);

   localparam chunk_cfg_type MIN_CHUNK_BITS = CHUNK_CFG_W'(6);
   localparam chunk_cfg_type CHUNK_BITS_RST = CHUNK_CFG_W'(8);
   localparam mod_type       TABLE_SIZE_RST = MOD_W'(257);
   localparam mod_type       MIN_TABLE_SIZE = MOD_W'(2);
   localparam coeff_type     COEFF_RST      = COEFF_W'(1);

   typedef struct packed {
      chunk_cfg_type chunk_bits;
      mod_type       table_size;
      logic          small_mod;
      coeff_vec_type coeff;
   } cfg_type;

   typedef struct packed {
      logic     valid;
      addr_type rest;
      sum_type  sum;
      prod_type prod;
   } chunk_link_type;

   typedef struct packed {
      logic    valid;
      div_type dividend;
      mod_type rem;
   } mod_link_type;

endpackage

`default_nettype wire

// ----- rtl/ipv4uh_if.sv -----
`default_nettype none

interface ipv4uh_req_if;
   logic                       valid;
   logic                       ready;
   logic [ipv4uh_pkg::ADDR_W-1:0] ip_address;

   modport source (output valid, output ip_address, input ready);
   modport sink   (input valid, input ip_address, output ready);
endinterface

interface ipv4uh_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ipv4uh_pkg::MOD_W-1:0] bucket_index;

   modport source (output valid, output bucket_index, input ready);
   modport sink   (input valid, input bucket_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/ipv4uh_csr.sv -----
`default_nettype none

module ipv4uh_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  ipv4uh_pkg::csr_idx_type  csr_index,
   input  ipv4uh_pkg::csr_data_type csr_wr_data,
   output ipv4uh_pkg::cfg_type      cfg
);
   import ipv4uh_pkg::*;

   chunk_cfg_type chunk_bits_ff, chunk_bits_in;
   mod_type       table_size_ff, table_size_in;
   coeff_vec_type coeff_ff, coeff_in;

   always_comb begin
      chunk_bits_in = chunk_bits_ff;
      table_size_in = table_size_ff;
      coeff_in      = coeff_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_CHUNK_BITS: begin
               chunk_bits_in = csr_wr_data[CHUNK_CFG_W-1:0];
            end
            REG_TABLE_SIZE: begin
               table_size_in = csr_wr_data[MOD_W-1:0];
            end
            default: begin
               for (int k = 0; k < MAX_CHUNKS; k++) begin
                  if (csr_index == CSR_IDX_W'(REG_COEFF_0 + k)) begin
                     coeff_in[k] = csr_wr_data[COEFF_W-1:0];
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_bits_ff <= CHUNK_BITS_RST;
         table_size_ff <= TABLE_SIZE_RST;
         coeff_ff      <= {MAX_CHUNKS{COEFF_RST}};
      end else begin
         chunk_bits_ff <= chunk_bits_in;
         table_size_ff <= table_size_in;
         coeff_ff      <= coeff_in;
      end
   end

   // narrow chunk widths are clamped up
   assign cfg.chunk_bits = (chunk_bits_ff < MIN_CHUNK_BITS) ? MIN_CHUNK_BITS : chunk_bits_ff;
   assign cfg.table_size = table_size_ff;
   assign cfg.small_mod  = (table_size_ff < MIN_TABLE_SIZE);
   assign cfg.coeff      = coeff_ff;

endmodule

`default_nettype wire

// ----- rtl/ipv4uh_chunk_cell.sv -----
`default_nettype none

module ipv4uh_chunk_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  ipv4uh_pkg::chunk_cfg_type  chunk_bits,
   input  ipv4uh_pkg::coeff_type      coeff,
   input  ipv4uh_pkg::chunk_link_type link_in,
   output ipv4uh_pkg::chunk_link_type link_out
);
   import ipv4uh_pkg::*;

   logic [ADDR_W:0] mask_wide;
   addr_type        chunk;

   logic     valid_ff, valid_in;
   addr_type rest_ff, rest_in;
   sum_type  sum_ff, sum_in;
   prod_type prod_ff, prod_in;

   // rest is already shifted down, so bits above the top chunk read as zero
   assign mask_wide = ({{ADDR_W{1'b0}}, 1'b1} << chunk_bits) - 1'b1;
   assign chunk     = link_in.rest & mask_wide[ADDR_W-1:0];

   assign valid_in = link_in.valid;
   assign rest_in  = link_in.rest >> chunk_bits;
   // fold in the product of the previous cell while this one multiplies
   assign sum_in   = link_in.sum + link_in.prod;
   assign prod_in  = chunk * coeff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rest_ff <= rest_in;
         sum_ff  <= sum_in;
         prod_ff <= prod_in;
      end
   end

   assign link_out.valid = valid_ff;
   assign link_out.rest  = rest_ff;
   assign link_out.sum   = sum_ff;
   assign link_out.prod  = prod_ff;

endmodule

`default_nettype wire

// ----- rtl/ipv4uh_mod_cell.sv -----
`default_nettype none

module ipv4uh_mod_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  ipv4uh_pkg::mod_type      table_size,
   input  ipv4uh_pkg::mod_link_type link_in,
   output ipv4uh_pkg::mod_link_type link_out
);
   import ipv4uh_pkg::*;

   logic [MOD_W:0] trial;
   mod_type        rem_step;

   logic    valid_ff, valid_in;
   div_type dividend_ff, dividend_in;
   mod_type rem_ff, rem_in;

   // restoring remainder, MSB first, MOD_STEP bits per cell
   always_comb begin
      trial    = '0;
      rem_step = link_in.rem;
      for (int j = 0; j < MOD_STEP; j++) begin
         trial = {rem_step, link_in.dividend[DIV_W-1-j]};
         if (trial >= {1'b0, table_size}) begin
            trial = trial - {1'b0, table_size};
         end
         rem_step = trial[MOD_W-1:0];
      end
   end

   assign valid_in    = link_in.valid;
   assign dividend_in = link_in.dividend << MOD_STEP;
   assign rem_in      = rem_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dividend_ff <= dividend_in;
         rem_ff      <= rem_in;
      end
   end

   assign link_out.valid    = valid_ff;
   assign link_out.dividend = dividend_ff;
   assign link_out.rem      = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/ipv4_universal_hash_top.sv -----
// Pipeline: MAX_CHUNKS + MOD_CELLS + 2 register stages (33 as configured): the chunk cells,
//   the accumulator register, the mod cells and the output register that holds bucket_index.
// Throughput: one address per cycle; one multiplier per chunk cell, one 2-bit remainder
//   step per mod cell. A stalled output holds the whole chain.
// Reset (synchronous): clears all valid bits; chunk_bits 8, table_size 257, coefficients 1.
`default_nettype none

module ipv4_universal_hash_top (
   input  logic                     clock,
   input  logic                     reset,
   ipv4uh_req_if.sink               req_chan,
   ipv4uh_rsp_if.source             rsp_chan,
   input  logic                     csr_wr_en,
   input  ipv4uh_pkg::csr_idx_type  csr_index,
   input  ipv4uh_pkg::csr_data_type csr_wr_data
);
   import ipv4uh_pkg::*;

   cfg_type        cfg;
   logic           advance;
   chunk_link_type chunk_link [MAX_CHUNKS+1];
   mod_link_type   mod_link [MOD_CELLS+1];

   logic    acc_valid_ff, acc_valid_in;
   sum_type acc_sum_ff, acc_sum_in;
   logic    out_valid_ff, out_valid_in;
   mod_type bucket_ff, bucket_in;

   ipv4uh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // whole chain moves unless the output register holds an untaken result
   assign advance        = !out_valid_ff || rsp_chan.ready;
   // no transaction is taken while reset is asserted
   assign req_chan.ready = advance && !reset;

   assign chunk_link[0].valid = req_chan.valid;
   assign chunk_link[0].rest  = req_chan.ip_address;
   assign chunk_link[0].sum   = '0;
   assign chunk_link[0].prod  = '0;

   for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_chunk
      ipv4uh_chunk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .chunk_bits (cfg.chunk_bits),
         .coeff      (cfg.coeff[g]),
         .link_in    (chunk_link[g]),
         .link_out   (chunk_link[g+1])
      );
   end

   assign acc_valid_in = chunk_link[MAX_CHUNKS].valid;
   assign acc_sum_in   = chunk_link[MAX_CHUNKS].sum + chunk_link[MAX_CHUNKS].prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
      end else if (advance) begin
         acc_valid_ff <= acc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_sum_ff <= acc_sum_in;
      end
   end

   assign mod_link[0].valid    = acc_valid_ff;
   assign mod_link[0].dividend = DIV_W'(acc_sum_ff);
   assign mod_link[0].rem      = '0;

   for (genvar g = 0; g < MOD_CELLS; g++) begin : g_mod
      ipv4uh_mod_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .table_size (cfg.table_size),
         .link_in    (mod_link[g]),
         .link_out   (mod_link[g+1])
      );
   end

   assign out_valid_in = mod_link[MOD_CELLS].valid;
   // table size 0 or 1 maps everything to bucket 0
   assign bucket_in    = cfg.small_mod ? '0 : mod_link[MOD_CELLS].rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bucket_ff <= bucket_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.bucket_index = bucket_ff;

endmodule

`default_nettype wire

// ----- rtl/ipv4uh_checker.sv -----
`default_nettype none
`include "ipv4_universal_hash_top_defines.svh"

module ipv4uh_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input ipv4uh_pkg::mod_type rsp_bucket_index
);
   import ipv4uh_pkg::*;

   // an empty output register never blocks the input side
   `IPV4UH_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "input refused with output empty")
   // a held result freezes the chain, so no transaction can enter
   `IPV4UH_ASSERT(a_stall_blocks_input, clock, reset, (rsp_valid && !rsp_ready) |-> !req_ready, "input taken during output stall")
   `IPV4UH_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_bucket_index)), "stalled result changed")
   `IPV4UH_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind ipv4_universal_hash_top ipv4uh_checker u_ipv4uh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_bucket_index (rsp_chan.bucket_index)
);

`default_nettype wire

// ----- verif/ipv4_universal_hash_top_tb.sv -----
module ipv4_universal_hash_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ipv4uh_pkg::*;

   localparam int CLK_HALF    = 4;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_WAIT  = 40;
   localparam int PHASES      = 12;
   localparam int DIR_ROWS    = 37;
   localparam int HOLD_CYCLES = 300;

   localparam csr_idx_type REG_COEFF_1 = REG_COEFF_0 + csr_idx_type'(1);
   localparam csr_idx_type REG_COEFF_2 = REG_COEFF_0 + csr_idx_type'(2);
   localparam csr_idx_type REG_COEFF_3 = REG_COEFF_0 + csr_idx_type'(3);
   localparam csr_idx_type REG_COEFF_4 = REG_COEFF_0 + csr_idx_type'(4);
   localparam csr_idx_type REG_COEFF_5 = REG_COEFF_0 + csr_idx_type'(5);

   typedef enum logic {ROW_WRITE, ROW_ADDR} row_op_type;

   typedef struct {
      row_op_type  op;
      csr_idx_type idx;
      logic [31:0] val;
      bit          fixed;
      mod_type     bucket;
   } dir_row_type;

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   csr_idx_type  csr_index;
   csr_data_type csr_wr_data;

   ipv4uh_req_if req_bus ();
   ipv4uh_rsp_if rsp_bus ();

   ipv4_universal_hash_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the block's registers
   chunk_cfg_type cfg_chunk;
   mod_type       cfg_mod;
   coeff_type     cfg_coeff [MAX_CHUNKS];

   mod_type     bucket_q [$];
   int unsigned err_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_req;

   // reset config hashes to the byte sum mod 257
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'h0000_0000, 1'b1, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hFFFF_FFFF, 1'b1, 18'd249},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'h0102_0304, 1'b1, 18'd10},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'h8000_0001, 1'b1, 18'd129},
      '{ROW_WRITE, REG_TABLE_SIZE, 32'd1,         1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hFFFF_FFFF, 1'b1, 18'd0},
      '{ROW_WRITE, REG_TABLE_SIZE, 32'd0,         1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'h1234_5678, 1'b1, 18'd0},
      '{ROW_WRITE, REG_TABLE_SIZE, 32'h3FFFF,     1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hFFFF_FFFF, 1'b1, 18'd1020},
      // chunk width below the minimum acts as 6: five full chunks plus 2 bits
      '{ROW_WRITE, REG_CHUNK_BITS, 32'd0,         1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hFFFF_FFFF, 1'b1, 18'd318},
      '{ROW_WRITE, REG_CHUNK_BITS, 32'd31,        1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hFFFF_FFFF, 1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'h7FFF_FFFF, 1'b0, 18'd0},
      '{ROW_WRITE, REG_CHUNK_BITS, 32'd16,        1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hFFFF_0001, 1'b0, 18'd0},
      '{ROW_WRITE, REG_COEFF_0,    32'd0,         1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'h0000_FFFF, 1'b1, 18'd0},
      '{ROW_WRITE, REG_COEFF_1,    32'h3FFFF,     1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hFFFF_FFFF, 1'b0, 18'd0},
      // upper data bits dropped, width becomes 15
      '{ROW_WRITE, REG_CHUNK_BITS, 32'h3FFEF,     1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hDEAD_BEEF, 1'b0, 18'd0},
      '{ROW_WRITE, REG_CHUNK_BITS, 32'd6,         1'b0, 18'd0},
      '{ROW_WRITE, REG_COEFF_2,    32'h3FFFF,     1'b0, 18'd0},
      '{ROW_WRITE, REG_COEFF_3,    32'h20000,     1'b0, 18'd0},
      '{ROW_WRITE, REG_COEFF_4,    32'd131101,    1'b0, 18'd0},
      '{ROW_WRITE, REG_COEFF_5,    32'h1FFFF,     1'b0, 18'd0},
      '{ROW_WRITE, REG_TABLE_SIZE, 32'd131101,    1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hFFFF_FFFF, 1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hAAAA_AAAA, 1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'h5555_5555, 1'b0, 18'd0},
      // five chunks, coeff_5 unused
      '{ROW_WRITE, REG_CHUNK_BITS, 32'd7,         1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hFFFF_FFFF, 1'b0, 18'd0},
      '{ROW_WRITE, REG_CHUNK_BITS, 32'd17,        1'b0, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'h0000_0000, 1'b1, 18'd0},
      '{ROW_ADDR,  REG_CHUNK_BITS, 32'hFFFF_FFFF, 1'b0, 18'd0}
   };

   always #(CLK_HALF) clock = ~clock;

   function automatic mod_type predict_bucket(input addr_type addr);
      int unsigned width;
      int unsigned pos;
      int unsigned span;
      longint unsigned piece;
      longint unsigned acc;
      width = (cfg_chunk < MIN_CHUNK_BITS) ? int'(MIN_CHUNK_BITS) : int'(cfg_chunk);
      pos   = 0;
      acc   = 0;
      for (int k = 0; k < MAX_CHUNKS && pos < ADDR_W; k++) begin
         span  = (ADDR_W - pos < width) ? ADDR_W - pos : width;
         piece = (64'(addr) >> pos) & ((64'd1 << span) - 64'd1);
         acc   = acc + piece * 64'(cfg_coeff[k]);
         pos   = pos + span;
      end
      if (cfg_mod < MIN_TABLE_SIZE)
         return '0;
      return mod_type'(acc % 64'(cfg_mod));
   endfunction

   task automatic flag_error(input string what, input mod_type want, input mod_type got);
      err_count++;
      if (err_count <= 10)
         $display("[%0t] MISMATCH %s: expected %0d actual %0d", $realtime, what, want, got);
   endtask

   // offer one address; returns at the falling edge after the transaction,
   // valid still high, so the caller must offer again or lower it
   task automatic push_addr(input addr_type addr, input bit fixed, input mod_type bucket);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.ip_address <= addr;
      do
         @(posedge clock);
      while (!req_bus.ready);
      bucket_q.insert(bucket_q.size(), fixed ? bucket : predict_bucket(addr));
      @(negedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (bucket_q.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   task automatic cfg_write(input csr_idx_type idx, input logic [31:0] val);
      csr_data_type data;
      data = csr_data_type'(val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      if (idx == REG_CHUNK_BITS)
         cfg_chunk = data[CHUNK_CFG_W-1:0];
      else if (idx == REG_TABLE_SIZE)
         cfg_mod = data;
      else
         cfg_coeff[idx - REG_COEFF_0] = data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic shuffle_cfg();
      logic [31:0] val;
      case ($urandom_range(5))
         0: val = 6;
         1: val = 16;
         2: val = 32'(CHUNK_BITS_RST);
         3: val = $urandom_range(17, 31);
         4: val = $urandom_range(0, 31);
         default: val = $urandom_range(0, 18'h3FFFF);
      endcase
      cfg_write(REG_CHUNK_BITS, val);
      case ($urandom_range(6))
         0: val = 131101;
         1: val = 32'(MIN_TABLE_SIZE);
         2: val = 32'(TABLE_SIZE_RST);
         3: val = $urandom_range(0, 1);
         4: val = 18'h3FFFF;
         default: val = $urandom_range(0, 18'h3FFFF);
      endcase
      cfg_write(REG_TABLE_SIZE, val);
      for (int k = 0; k < MAX_CHUNKS; k++) begin
         case ($urandom_range(5))
            0: val = 0;
            1: val = 32'(COEFF_RST);
            2: val = 131101;
            3: val = 18'h3FFFF;
            default: val = $urandom_range(0, 18'h3FFFF);
         endcase
         cfg_write(REG_COEFF_0 + csr_idx_type'(k), val);
      end
   endtask

   // result side: random back-pressure plus an occasional long hold
   initial begin : rsp_drive
      int unsigned hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      mod_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (bucket_q.size() == 0) begin
            flag_error("unexpected transaction", '0, rsp_bus.bucket_index);
         end else begin
            want = bucket_q.pop_front();
            if (rsp_bus.bucket_index !== want)
               flag_error("bucket_index", want, rsp_bus.bucket_index);
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("ipv4_universal_hash_top verification failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned n_items;
      addr_type    addr;
      clock              = 1'b0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = REG_CHUNK_BITS;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.ip_address = '0;
      err_count          = 0;
      hold_req           = 0;
      send_idle_pct      = 21;
      recv_idle_pct      = 47;
      cfg_chunk          = CHUNK_BITS_RST;
      cfg_mod            = TABLE_SIZE_RST;
      for (int k = 0; k < MAX_CHUNKS; k++)
         cfg_coeff[k] = COEFF_RST;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].op == ROW_WRITE) begin
            settle();
            cfg_write(dir_tab[i].idx, dir_tab[i].val);
         end else begin
            push_addr(dir_tab[i].val, dir_tab[i].fixed, dir_tab[i].bucket);
         end
      end
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < PHASES / 3) begin
            send_idle_pct = 21;
            recv_idle_pct = 47;
         end else if (ph < 2 * PHASES / 3) begin
            send_idle_pct = 47;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         shuffle_cfg();
         n_items = $urandom_range(80, 104);
         for (int n = 0; n < n_items; n++) begin
            // long output stall while addresses keep coming: pipeline fills up
            if ((ph == 1 || ph == PHASES - 1) && n == 10)
               hold_req = HOLD_CYCLES;
            case ($urandom_range(9))
               0: addr = '0;
               1: addr = '1;
               2: addr = addr_type'(1) << $urandom_range(ADDR_W - 1);
               default: addr = $urandom;
            endcase
            push_addr(addr, 1'b0, '0);
         end
         settle();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (bucket_q.size() != 0)
         flag_error("transaction never returned", bucket_q[0], '0);
      if (err_count == 0)
         $display("ipv4_universal_hash_top verification clean");
      else
         $display("ipv4_universal_hash_top verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ipv4uh_pkg.sv
rtl/ipv4uh_if.sv
rtl/ipv4uh_csr.sv
rtl/ipv4uh_chunk_cell.sv
rtl/ipv4uh_mod_cell.sv
rtl/ipv4_universal_hash_top.sv
rtl/ipv4uh_checker.sv
verif/ipv4_universal_hash_top_tb.sv
